>>> src/arsm_pkg.sv
package arsm_pkg;

  // Block dimensions.
  localparam int ANTENNAS = 4;
  localparam int HISTORY  = 8;

  // Derived widths.
  localparam int ANT_W    = (ANTENNAS > 1) ? $clog2(ANTENNAS) : 1;
  localparam int SLOT_W   = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int CNT_W    = $clog2(HISTORY + 1);
  localparam int SUM_W    = $clog2(HISTORY) + 8;
  localparam int MAG_W    = SUM_W;
  localparam int ITER_W   = $clog2(MAG_W + 1);
  localparam int RING_D   = ANTENNAS * HISTORY;
  localparam int RING_AW  = (RING_D > 1) ? $clog2(RING_D) : 1;

  // Configuration register word indexes.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic [7:0] THRESHOLD_RESET = 8'd10;

  // Input beat.
  typedef struct packed {
    logic [3:0]        antenna_index;
    logic signed [7:0] rssi_sample;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic              accepted;
    logic signed [7:0] antenna_average;
    logic [7:0]        average_spread;
    logic              weak_antenna;
    logic [4:0]        antennas_seen;
  } out_beat_t;

  // Divider request and status.
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_SCAN,
    S_FINISH
  } seq_state_t;

  // Ring address of one antenna's slot.
  function automatic logic [RING_AW-1:0] ring_addr(input logic [ANT_W-1:0] ant,
                                                   input logic [SLOT_W-1:0] slot);
    logic [RING_AW+SLOT_W:0] full;
    full = (RING_AW+SLOT_W+1)'(ant) * (RING_AW+SLOT_W+1)'(HISTORY)
           + (RING_AW+SLOT_W+1)'(slot);
    return full[RING_AW-1:0];
  endfunction

endpackage

>>> src/arsm_ring.sv
module arsm_ring
  import arsm_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [RING_AW-1:0]  waddr,
  input  logic signed [7:0]   wdata,
  input  logic                re,
  input  logic [RING_AW-1:0]  raddr,
  output logic signed [7:0]   rdata_r
);

  // Sample history of all antennas, one row of HISTORY entries per antenna.
  logic signed [7:0] mem [RING_D];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> src/arsm_div.sv
module arsm_div
  import arsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output div_status_t       status,
  output logic signed [7:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [MAG_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvsr_r, dvsr_nxt;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem_r, q_r[MAG_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    iter_nxt = iter_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.dividend[SUM_W-1];
      q_nxt    = req.dividend[SUM_W-1] ? MAG_W'(-req.dividend) : MAG_W'(req.dividend);
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
      iter_nxt = ITER_W'(MAG_W);
    end else if (busy_r) begin
      q_nxt    = {q_r[MAG_W-2:0], fits};
      rem_nxt  = fits ? CNT_W'(rem_sh - {1'b0, dvsr_r}) : rem_sh[CNT_W-1:0];
      iter_nxt = iter_r - ITER_W'(1);
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    iter_r <= iter_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  // Quotient magnitude never exceeds 128, so eight bits carry the signed result.
  assign quotient    = neg_r ? 8'(-q_r) : 8'(q_r);
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> src/antenna_rssi_spread_monitor.sv
// Antenna RSSI spread monitor. Each input beat carries one RSSI sample and an
// antenna index; every input beat produces exactly one result beat with the
// antenna's new rolling average over its last HISTORY samples, the spread
// between the largest and smallest average of all antennas holding samples,
// the weak flag (spread at or above the threshold, or the previous flag for a
// dropped sample) and the highest accepted index plus one. A sample whose
// index is ANTENNAS or more is dropped and reported with accepted low. An
// accepted sample passes through the update, the bit-serial divider, which
// forms one quotient bit per cycle, and the spread scan, which visits one
// antenna per cycle; a dropped one goes straight to the scan. in_stall is
// high while a sample is at work; a result waits in the output register
// while the next sample is taken.
// The threshold is written at byte address 0 over the APB-style port.
module antenna_rssi_spread_monitor
  import arsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  seq_state_t state_r, state_nxt;

  logic [7:0]              threshold_r;
  logic [CNT_W-1:0]        fill_count_r [ANTENNAS];
  logic [SLOT_W-1:0]       write_slot_r [ANTENNAS];
  logic signed [SUM_W-1:0] running_sum_r [ANTENNAS];
  logic signed [7:0]       rolling_avg_r [ANTENNAS];
  logic                    weak_flag_r;
  logic [4:0]              highest_seen_r;

  logic [ANT_W-1:0]  ant_r;
  logic signed [7:0] rssi_r;
  logic              take_r;
  logic [ANT_W-1:0]  scan_idx_r;
  logic              any_r;
  logic signed [7:0] lo_r, hi_r;

  logic              out_valid_r;
  out_beat_t         out_data_r;

  logic              in_fire;
  logic              in_range;
  logic [ANT_W-1:0]  in_ant;
  logic              out_free;
  logic              scan_last;
  logic              ring_we, ring_re;
  logic [RING_AW-1:0] ring_raddr, ring_waddr;
  logic signed [7:0] ring_rdata;
  logic              full;
  logic signed [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0]  fill_new;
  logic [4:0]        seen_cand;
  logic signed [7:0] scan_avg;
  logic              scan_has;
  logic [7:0]        spread;
  logic              weak_new;
  div_req_t          div_req;
  div_status_t       div_st;
  logic signed [7:0] div_q;

  // Handshake decode.
  assign in_fire   = in_valid && !in_stall;
  assign in_range  = ({1'b0, in_data.antenna_index} < 5'(ANTENNAS));
  assign in_ant    = in_data.antenna_index[ANT_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_last = (scan_idx_r == ANT_W'(ANTENNAS - 1));

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {24'd0, threshold_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
      threshold_r <= pwdata[7:0];
    end
  end

  // Sample ring and the update of the antenna's sum.
  assign ring_re    = in_fire && in_range;
  assign ring_raddr = ring_addr(in_ant, write_slot_r[in_ant]);
  assign ring_waddr = ring_addr(ant_r, write_slot_r[ant_r]);
  assign full       = (fill_count_r[ant_r] >= CNT_W'(HISTORY));
  assign sum_new    = (full ? running_sum_r[ant_r] - SUM_W'(ring_rdata)
                            : running_sum_r[ant_r]) + SUM_W'(rssi_r);
  assign fill_new   = full ? fill_count_r[ant_r] : fill_count_r[ant_r] + CNT_W'(1);
  assign seen_cand  = 5'(ant_r) + 5'd1;

  arsm_ring u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (ring_waddr),
    .wdata   (rssi_r),
    .re      (ring_re),
    .raddr   (ring_raddr),
    .rdata_r (ring_rdata)
  );

  // Shared divider for sum over fill count.
  assign div_req.start    = (state_r == S_UPDATE);
  assign div_req.dividend = sum_new;
  assign div_req.divisor  = fill_new;

  arsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .status   (div_st),
    .quotient (div_q)
  );

  // Spread scan, one antenna per cycle.
  assign scan_avg = rolling_avg_r[scan_idx_r];
  assign scan_has = (fill_count_r[scan_idx_r] != '0);
  assign spread   = any_r ? 8'(hi_r - lo_r) : 8'd0;
  assign weak_new = take_r ? (spread >= threshold_r) : weak_flag_r;

  // Sequencer next state and strobes.
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    ring_we   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = in_range ? S_UPDATE : S_SCAN;
        end
      end
      S_UPDATE: begin
        ring_we   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_st.done) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Per-antenna state and the flags kept across samples.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ANTENNAS; i++) begin
        fill_count_r[i]  <= '0;
        write_slot_r[i]  <= '0;
        running_sum_r[i] <= '0;
        rolling_avg_r[i] <= '0;
      end
      weak_flag_r    <= 1'b0;
      highest_seen_r <= '0;
    end else begin
      if (state_r == S_UPDATE) begin
        fill_count_r[ant_r]  <= fill_new;
        running_sum_r[ant_r] <= sum_new;
        write_slot_r[ant_r]  <= (write_slot_r[ant_r] == SLOT_W'(HISTORY - 1))
                                ? '0 : write_slot_r[ant_r] + SLOT_W'(1);
        if (seen_cand > highest_seen_r) begin
          highest_seen_r <= seen_cand;
        end
      end
      if (state_r == S_DIV && div_st.done) begin
        rolling_avg_r[ant_r] <= div_q;
      end
      if (state_r == S_FINISH && out_free) begin
        weak_flag_r <= weak_new;
      end
    end
  end

  // Latched sample and scan registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ant_r      <= in_ant;
      rssi_r     <= in_data.rssi_sample;
      take_r     <= in_range;
      scan_idx_r <= '0;
      any_r      <= 1'b0;
    end else if (state_r == S_SCAN) begin
      if (scan_has) begin
        if (!any_r || scan_avg < lo_r) begin
          lo_r <= scan_avg;
        end
        if (!any_r || scan_avg > hi_r) begin
          hi_r <= scan_avg;
        end
        any_r <= 1'b1;
      end
      if (!scan_last) begin
        scan_idx_r <= scan_idx_r + ANT_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_free) begin
      out_data_r.accepted        <= take_r;
      out_data_r.antenna_average <= take_r ? rolling_avg_r[ant_r] : 8'sd0;
      out_data_r.average_spread  <= spread;
      out_data_r.weak_antenna    <= weak_new;
      out_data_r.antennas_seen   <= highest_seen_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A dropped sample reports a zero average.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.accepted |-> out_data_r.antenna_average == 8'sd0)
    else $error("dropped sample reported a nonzero average");

  // An accepted sample always leaves at least one antenna seen.
  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.accepted |-> out_data_r.antennas_seen != 5'd0)
    else $error("accepted sample with no antenna seen");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");

  // A fresh result on an accepted sample carries the threshold comparison.
  a_weak: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_data_r.accepted |->
      out_data_r.weak_antenna == (out_data_r.average_spread >= threshold_r))
    else $error("weak flag disagrees with spread and threshold");

endmodule
